@@ design/aso_pkg.sv @@
package aso_pkg;

  localparam int DT_W       = 24;
  localparam int CMD_W      = 32;
  localparam int TAU_W      = 32;
  localparam int QUANT_W    = 25;
  localparam int KIND_W     = 2;
  localparam int MULT_W     = 24;
  localparam int STEP_W     = 5;
  localparam int FRAC_W     = 16;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [KIND_W-1:0] {
    REQ_PREDICT = 2'd0,
    REQ_UPDATE  = 2'd1,
    REQ_SMOOTH  = 2'd2,
    REQ_RESET   = 2'd3
  } req_kind_e;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_CONSTANT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_STEP    = 1'b1;

  localparam logic [TAU_W-1:0]   TAU_MIN     = 32'd16777;
  localparam logic [TAU_W-1:0]   TAU_RESET   = 32'd1677722;
  localparam logic [QUANT_W-1:0] QUANT_MIN   = 25'd17;
  localparam logic [QUANT_W-1:0] QUANT_MAX   = 25'd16777216;
  localparam logic [QUANT_W-1:0] QUANT_RESET = 25'd6711;

  // Q16 gains
  localparam logic [COEF_W-1:0] COEF_CMD_POS  = 16'd58982;  // 0.90
  localparam logic [COEF_W-1:0] COEF_VEL_POS  = 16'd6554;   // 0.10
  localparam logic [COEF_W-1:0] COEF_VEL_KEEP = 16'd64225;  // 0.98
  localparam logic [COEF_W-1:0] COEF_CMD_PULL = 16'd1311;   // 0.02

  localparam logic [STEP_W-1:0] STEPS_Q16  = 5'd16;
  localparam logic [STEP_W-1:0] STEPS_FULL = 5'd24;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } mul_ctl_t;

endpackage

@@ design/aso_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
// The multiplier is left aligned: only its top ctl_i.steps bits are used.
module aso_mul #(
  parameter int XW = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  aso_pkg::mul_ctl_t                   ctl_i,
  input  logic [XW-1:0]                       mcand_i,
  input  logic [aso_pkg::MULT_W-1:0]          mplr_i,
  output logic                                done_o,
  output logic [XW+aso_pkg::MULT_W-1:0]       prod_o
);

  localparam int PW = XW + aso_pkg::MULT_W;

  logic [aso_pkg::STEP_W-1:0] cnt_q;
  logic                       done_q;
  logic [PW-1:0]              acc_q;
  logic [XW-1:0]              mcand_q;
  logic [aso_pkg::MULT_W-1:0] mplr_q;
  logic [PW-1:0]              addend;

  assign addend = mplr_q[aso_pkg::MULT_W-1] ? {{aso_pkg::MULT_W{1'b0}}, mcand_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (ctl_i.start) begin
      cnt_q  <= ctl_i.steps;
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == {{(aso_pkg::STEP_W-1){1'b0}}, 1'b1});
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      acc_q   <= '0;
      mcand_q <= mcand_i;
      mplr_q  <= mplr_i;
    end else if (cnt_q != '0) begin
      acc_q  <= {acc_q[PW-2:0], 1'b0} + addend;
      mplr_q <= {mplr_q[aso_pkg::MULT_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ design/aso_div.sv @@
// Restoring divider for the smoothing gain: floor(dt * 2^24 / (tau + dt)).
// One quotient bit per cycle; the quotient always fits in DT_W bits.
module aso_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [aso_pkg::DT_W-1:0]   dt_i,
  input  logic [aso_pkg::TAU_W-1:0]  tau_i,
  output logic                       done_o,
  output logic [aso_pkg::DT_W-1:0]   quot_o
);

  localparam int RW = aso_pkg::TAU_W + 1;

  logic [aso_pkg::STEP_W-1:0] cnt_q;
  logic                       done_q;
  logic [RW-1:0]              den_q;
  logic [RW-1:0]              rem_q;
  logic [aso_pkg::DT_W-1:0]   quot_q;
  logic [RW:0]                rem2;
  logic [RW:0]                rem_sub;
  logic                       fits;

  assign rem2    = {rem_q, 1'b0};
  assign rem_sub = rem2 - {1'b0, den_q};
  assign fits    = rem2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= aso_pkg::STEP_W'(aso_pkg::DT_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == {{(aso_pkg::STEP_W-1){1'b0}}, 1'b1});
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= {1'b0, tau_i} + RW'(dt_i);
      rem_q <= RW'(dt_i);
    end else if (cnt_q != '0) begin
      rem_q  <= fits ? rem_sub[RW-1:0] : rem2[RW-1:0];
      quot_q <= {quot_q[aso_pkg::DT_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ design/angle_snap_observer.sv @@
// Update, reset, and predict/smooth requests that change nothing, need no arithmetic;
// predict runs five products on the shared shift-add multiplier (the dt product on all 24 multiplier
// bits, the others on the top 16), smooth a divide and then one product.
// Requests are handled one at a time: the next is taken the cycle after the result is registered,
// or later while a full output register is held off.
// Reset (async, active low): state zeroed, not initialized, tau 1677722, quant step 6711.
module angle_snap_observer #(
  parameter int ANGLE_WIDTH    = 40,
  parameter int VELOCITY_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // time_step, command_velocity, angle_value, reset_velocity, zero pad
  input  logic [((aso_pkg::DT_W + aso_pkg::CMD_W + ANGLE_WIDTH + VELOCITY_WIDTH + 7) / 8) * 8 - 1:0]
                                                s_axis_tdata,
  // req_type
  input  logic [aso_pkg::KIND_W-1:0]            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // position_estimate, velocity_estimate, zero pad
  output logic [((ANGLE_WIDTH + VELOCITY_WIDTH + 7) / 8) * 8 - 1:0]
                                                m_axis_tdata,
  // is_initialized, measurement_taken
  output logic [1:0]                            m_axis_tuser,
  input  logic                                  cfg_we_i,
  input  logic [aso_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [aso_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int AW       = ANGLE_WIDTH;
  localparam int VW       = VELOCITY_WIDTH;
  localparam int OUT_DW   = ((AW + VW + 7) / 8) * 8;
  localparam int OFF_CMD  = aso_pkg::DT_W;
  localparam int OFF_ANG  = OFF_CMD + aso_pkg::CMD_W;
  localparam int OFF_RVEL = OFF_ANG + AW;
  // |blended velocity| < 2^MW
  localparam int MW       = ((VW > aso_pkg::CMD_W) ? VW : aso_pkg::CMD_W) + 1;
  localparam int TW       = MW + 1;
  localparam int XW       = (AW > MW) ? AW : MW;
  localparam int PW       = XW + aso_pkg::MULT_W;
  localparam int QW       = XW + 9;
  localparam int SW       = XW + 10;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_LAUNCH = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_DIVW   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  localparam logic [2:0] PH_CMD_POS  = 3'd0;
  localparam logic [2:0] PH_VEL_POS  = 3'd1;
  localparam logic [2:0] PH_DT       = 3'd2;
  localparam logic [2:0] PH_VEL_KEEP = 3'd3;
  localparam logic [2:0] PH_CMD_PULL = 3'd4;
  localparam logic [2:0] PH_DIV      = 3'd5;
  localparam logic [2:0] PH_SMOOTH   = 3'd6;

  localparam logic [AW-1:0] ANG_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic [AW-1:0] ANG_MIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic [VW-1:0] VEL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VEL_MIN = {1'b1, {(VW-1){1'b0}}};

  localparam int PAD_W = aso_pkg::MULT_W - aso_pkg::COEF_W;

  logic [2:0] state_q;
  logic [2:0] phase_q;

  logic signed [AW-1:0]          pos_q;
  logic signed [AW-1:0]          tgt_q;
  logic signed [AW-1:0]          last_q;
  logic signed [VW-1:0]          vel_q;
  logic                          init_q;
  logic                          taken_q;
  logic [aso_pkg::TAU_W-1:0]     tau_q;
  logic [aso_pkg::QUANT_W-1:0]   quant_q;
  logic                          out_valid_q;

  aso_pkg::req_kind_e            kind_q;
  logic [aso_pkg::DT_W-1:0]      dt_q;
  logic signed [aso_pkg::CMD_W-1:0] cmd_q;
  logic signed [AW-1:0]          ang_q;
  logic signed [VW-1:0]          rvel_q;
  logic signed [TW-1:0]          tmp_q;
  logic                          neg_q;
  logic [aso_pkg::MULT_W-1:0]    alpha_q;
  logic [AW-1:0]                 out_pos_q;
  logic [VW-1:0]                 out_vel_q;
  logic                          out_init_q;
  logic                          out_taken_q;

  logic                          in_acc;
  logic                          out_load;
  logic [aso_pkg::CMD_W-1:0]     cmd_mag;
  logic [VW-1:0]                 vel_mag;
  logic [TW-1:0]                 tmp_neg;
  logic [TW-2:0]                 tmp_mag;
  logic [AW:0]                   sm_dif;
  logic [AW:0]                   sm_neg;
  logic                          sm_up;
  logic [AW-1:0]                 sm_mag;
  logic [AW:0]                   up_dif;
  logic [AW:0]                   up_neg;
  logic [AW-1:0]                 up_mag;
  logic [aso_pkg::QUANT_W:0]     quant_inc;
  logic                          meas_far;
  logic [aso_pkg::QUANT_W-1:0]   quant_wr;

  aso_pkg::mul_ctl_t             mul_ctl;
  logic [XW-1:0]                 mul_mcand;
  logic [aso_pkg::MULT_W-1:0]    mul_mplr;
  logic                          mul_neg;
  logic                          mul_done;
  logic [PW-1:0]                 mul_prod;
  logic                          div_start;
  logic                          div_done;
  logic [aso_pkg::DT_W-1:0]      div_quot;

  logic [QW-1:0]                 q16u;
  logic signed [QW-1:0]          q16s;
  logic signed [SW-1:0]          psum;
  logic [AW-1:0]                 pos_pred;
  logic signed [TW-1:0]          vsum;
  logic [VW-1:0]                 vel_pred;
  logic [AW-1:0]                 step_s;
  logic [AW-1:0]                 pos_smooth;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  // magnitudes of the multiplicands
  assign cmd_mag = cmd_q[aso_pkg::CMD_W-1] ? (~cmd_q + 1'b1) : cmd_q;
  assign vel_mag = vel_q[VW-1] ? (~vel_q + 1'b1) : vel_q;
  assign tmp_neg = ~tmp_q + 1'b1;
  assign tmp_mag = tmp_q[TW-1] ? tmp_neg[TW-2:0] : tmp_q[TW-2:0];

  assign sm_dif = {tgt_q[AW-1], tgt_q} - {pos_q[AW-1], pos_q};
  assign sm_neg = ~sm_dif + 1'b1;
  assign sm_up  = !sm_dif[AW];
  assign sm_mag = sm_up ? sm_dif[AW-1:0] : sm_neg[AW-1:0];

  // measurement is new when 2*|ang - last| >= quant, i.e. |d| >= ceil(quant/2)
  assign up_dif    = {ang_q[AW-1], ang_q} - {last_q[AW-1], last_q};
  assign up_neg    = ~up_dif + 1'b1;
  assign up_mag    = up_dif[AW] ? up_neg[AW-1:0] : up_dif[AW-1:0];
  assign quant_inc = {1'b0, quant_q} + 1'b1;
  assign meas_far  = up_mag >= {{(AW-aso_pkg::QUANT_W){1'b0}}, quant_inc[aso_pkg::QUANT_W:1]};

  assign quant_wr = cfg_data_i[aso_pkg::QUANT_W-1:0];

  always_comb begin
    mul_ctl.start = (state_q == ST_LAUNCH) && (phase_q != PH_DIV);
    mul_ctl.steps = aso_pkg::STEPS_Q16;
    mul_mcand     = XW'(vel_mag);
    mul_mplr      = {aso_pkg::COEF_VEL_POS, {PAD_W{1'b0}}};
    mul_neg       = vel_q[VW-1];
    case (phase_q)
      PH_CMD_POS: begin
        mul_mcand = XW'(cmd_mag);
        mul_mplr  = {aso_pkg::COEF_CMD_POS, {PAD_W{1'b0}}};
        mul_neg   = cmd_q[aso_pkg::CMD_W-1];
      end
      PH_VEL_POS: begin
        mul_mcand = XW'(vel_mag);
        mul_mplr  = {aso_pkg::COEF_VEL_POS, {PAD_W{1'b0}}};
        mul_neg   = vel_q[VW-1];
      end
      PH_DT: begin
        mul_ctl.steps = aso_pkg::STEPS_FULL;
        mul_mcand     = XW'(tmp_mag);
        mul_mplr      = dt_q;
        mul_neg       = tmp_q[TW-1];
      end
      PH_VEL_KEEP: begin
        mul_mcand = XW'(vel_mag);
        mul_mplr  = {aso_pkg::COEF_VEL_KEEP, {PAD_W{1'b0}}};
        mul_neg   = vel_q[VW-1];
      end
      PH_CMD_PULL: begin
        mul_mcand = XW'(cmd_mag);
        mul_mplr  = {aso_pkg::COEF_CMD_PULL, {PAD_W{1'b0}}};
        mul_neg   = cmd_q[aso_pkg::CMD_W-1];
      end
      PH_SMOOTH: begin
        mul_ctl.steps = aso_pkg::STEPS_FULL;
        mul_mcand     = XW'(sm_mag);
        mul_mplr      = alpha_q;
        mul_neg       = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign div_start = (state_q == ST_LAUNCH) && (phase_q == PH_DIV);

  aso_mul #(
    .XW (XW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mul_ctl),
    .mcand_i (mul_mcand),
    .mplr_i  (mul_mplr),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  aso_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dt_i    (dt_q),
    .tau_i   (tau_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Q16 product truncated toward zero
  assign q16u = {1'b0, mul_prod[PW-1:aso_pkg::FRAC_W]};
  assign q16s = neg_q ? -q16u : q16u;

  assign psum     = SW'(pos_q) + SW'(q16s);
  assign pos_pred = (&psum[SW-1:AW-1] || ~|psum[SW-1:AW-1]) ? psum[AW-1:0] :
                    (psum[SW-1] ? ANG_MIN : ANG_MAX);

  assign vsum     = tmp_q + q16s[TW-1:0];
  assign vel_pred = (&vsum[TW-1:VW-1] || ~|vsum[TW-1:VW-1]) ? vsum[VW-1:0] :
                    (vsum[TW-1] ? VEL_MIN : VEL_MAX);

  // the step never passes the target, so it fits the angle width
  assign step_s     = mul_prod[aso_pkg::MULT_W+AW-1:aso_pkg::MULT_W];
  assign pos_smooth = sm_up ? (pos_q + step_s) : (pos_q - step_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_CMD_POS;
      pos_q       <= '0;
      tgt_q       <= '0;
      last_q      <= '0;
      vel_q       <= '0;
      init_q      <= 1'b0;
      taken_q     <= 1'b0;
      tau_q       <= aso_pkg::TAU_RESET;
      quant_q     <= aso_pkg::QUANT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          aso_pkg::REG_TIME_CONSTANT: begin
            tau_q <= (cfg_data_i < aso_pkg::TAU_MIN) ? aso_pkg::TAU_MIN : cfg_data_i;
          end
          aso_pkg::REG_QUANT_STEP: begin
            quant_q <= (quant_wr < aso_pkg::QUANT_MIN || quant_wr > aso_pkg::QUANT_MAX) ?
                       aso_pkg::QUANT_RESET : quant_wr;
          end
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            taken_q <= 1'b0;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (kind_q)
            aso_pkg::REQ_PREDICT: begin
              if (init_q && dt_q != '0) begin
                phase_q <= PH_CMD_POS;
                state_q <= ST_LAUNCH;
              end else begin
                state_q <= ST_DONE;
              end
            end
            aso_pkg::REQ_SMOOTH: begin
              if (init_q && dt_q != '0) begin
                phase_q <= PH_DIV;
                state_q <= ST_LAUNCH;
              end else begin
                state_q <= ST_DONE;
              end
            end
            aso_pkg::REQ_UPDATE: begin
              state_q <= ST_DONE;
              if (!init_q) begin
                pos_q   <= ang_q;
                tgt_q   <= ang_q;
                last_q  <= ang_q;
                vel_q   <= '0;
                init_q  <= 1'b1;
                taken_q <= 1'b1;
              end else if (meas_far) begin
                tgt_q   <= ang_q;
                last_q  <= ang_q;
                taken_q <= 1'b1;
              end
            end
            aso_pkg::REQ_RESET: begin
              state_q <= ST_DONE;
              pos_q   <= ang_q;
              tgt_q   <= ang_q;
              last_q  <= ang_q;
              vel_q   <= rvel_q;
              init_q  <= 1'b1;
            end
            default: begin
              state_q <= ST_DONE;
            end
          endcase
        end
        ST_LAUNCH: begin
          state_q <= (phase_q == PH_DIV) ? ST_DIVW : ST_MUL;
        end
        ST_DIVW: begin
          if (div_done) begin
            phase_q <= PH_SMOOTH;
            state_q <= ST_LAUNCH;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            case (phase_q)
              PH_CMD_POS: begin
                phase_q <= PH_VEL_POS;
                state_q <= ST_LAUNCH;
              end
              PH_VEL_POS: begin
                phase_q <= PH_DT;
                state_q <= ST_LAUNCH;
              end
              PH_DT: begin
                pos_q   <= pos_pred;
                phase_q <= PH_VEL_KEEP;
                state_q <= ST_LAUNCH;
              end
              PH_VEL_KEEP: begin
                phase_q <= PH_CMD_PULL;
                state_q <= ST_LAUNCH;
              end
              PH_CMD_PULL: begin
                vel_q   <= vel_pred;
                state_q <= ST_DONE;
              end
              PH_SMOOTH: begin
                pos_q   <= pos_smooth;
                state_q <= ST_DONE;
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= aso_pkg::req_kind_e'(s_axis_tuser);
      dt_q   <= s_axis_tdata[aso_pkg::DT_W-1:0];
      cmd_q  <= s_axis_tdata[OFF_ANG-1:OFF_CMD];
      ang_q  <= s_axis_tdata[OFF_RVEL-1:OFF_ANG];
      rvel_q <= s_axis_tdata[OFF_RVEL+VW-1:OFF_RVEL];
    end
    if (state_q == ST_LAUNCH) begin
      neg_q <= mul_neg;
    end
    if (state_q == ST_DIVW && div_done) begin
      alpha_q <= div_quot;
    end
    if (state_q == ST_MUL && mul_done) begin
      case (phase_q)
        PH_CMD_POS:  tmp_q <= q16s[TW-1:0];
        PH_VEL_POS:  tmp_q <= tmp_q + q16s[TW-1:0];
        PH_VEL_KEEP: tmp_q <= q16s[TW-1:0];
        default: begin
        end
      endcase
    end
    if (out_load) begin
      out_pos_q   <= pos_q;
      out_vel_q   <= vel_q;
      out_init_q  <= init_q;
      out_taken_q <= taken_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DW'({out_vel_q, out_pos_q});
  assign m_axis_tuser  = {out_taken_q, out_init_q};

  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_MUL)
    else $error("multiplier finished outside its wait state");

  a_div_done_in_divw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIVW)
    else $error("divider finished outside its wait state");

  a_init_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |=> init_q)
    else $error("initialized flag dropped");

  a_taken_implies_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
    else $error("measurement taken while not initialized");

  a_done_waits_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !m_axis_tready) |=> state_q == ST_DONE)
    else $error("result dropped while output register was full");

endmodule
